@@ src/top_byte_short_code_packer_macros.svh @@
// ---------------------------------------------------------------------------
// top_byte_short_code_packer_macros
// Assertion macros used by the port checker of the packer.
// ---------------------------------------------------------------------------
`ifndef TOP_BYTE_SHORT_CODE_PACKER_MACROS_SVH
`define TOP_BYTE_SHORT_CODE_PACKER_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define BSCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define BSCP_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bscp_pkg.sv @@
// ---------------------------------------------------------------------------
// bscp_pkg
// Shared constants and types of the byte short code packer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bscp_pkg;

	localparam int TABLE_ENTRIES_DEF = 15;
	localparam int TABLE_ENTRIES_MAX = 15;
	localparam int TABLE_BITS        = 8 * TABLE_ENTRIES_MAX;
	localparam int LOW_BITS          = 64;
	localparam int HIGH_BITS         = 56;
	localparam int COUNT_BITS        = 4;
	localparam int SHORT_LEN         = 5;
	localparam int RAW_LEN           = 8;
	localparam int OBUF_DEPTH        = 2;

	localparam logic [COUNT_BITS-1:0] ENTRY_COUNT_RST = 4'd15;

	localparam logic [1:0] CFG_TABLE_LOW   = 2'd0;
	localparam logic [1:0] CFG_TABLE_HIGH  = 2'd1;
	localparam logic [1:0] CFG_ENTRY_COUNT = 2'd2;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} match_t;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;
		logic       last;
	} pair_t;

endpackage

@@ src/bscp_match.sv @@
// ---------------------------------------------------------------------------
// bscp_match
// Parallel compare of one byte against the table, lowest index wins.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bscp_match #(
	parameter int TABLE_ENTRIES = bscp_pkg::TABLE_ENTRIES_DEF
) (
	input  logic [bscp_pkg::TABLE_BITS-1:0] table_bytes,
	input  logic [bscp_pkg::COUNT_BITS-1:0] entry_count,
	input  logic [7:0]                      data_byte,
	output bscp_pkg::match_t                result
);

	logic [TABLE_ENTRIES-1:0] hit;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit[i] = (4'(i) < entry_count) && (table_bytes[8*i +: 8] == data_byte);
		end
	end

	always_comb begin
		result.hit = 1'b0;
		result.idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				result.hit = 1'b1;
				result.idx = 4'(i);
			end
		end
	end

endmodule

@@ src/bscp_pack.sv @@
// ---------------------------------------------------------------------------
// bscp_pack
// Input register, code selection and bit packer with pending state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bscp_pack #(
	parameter int TABLE_ENTRIES = bscp_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bscp_pkg::TABLE_BITS-1:0] table_bytes,
	input  logic [bscp_pkg::COUNT_BITS-1:0] entry_count,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_byte,
	input  logic                            in_last,
	input  logic                            room,
	output logic                            push,
	output bscp_pkg::pair_t                 pair
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [6:0]       pend_bits_q;
	logic [2:0]       pend_count_q;

	bscp_pkg::match_t mres;
	logic             fire;
	logic [7:0]       code;
	logic [3:0]       len;
	logic [3:0]       total;
	logic [14:0]      acc;
	logic             full;
	logic [2:0]       rem;
	logic [6:0]       rem_bits;
	logic [7:0]       full_byte;
	logic [14:0]      pad_w;
	logic [7:0]       pad_byte;
	logic             flush;

	bscp_match #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_match (
		.table_bytes(table_bytes),
		.entry_count(entry_count),
		.data_byte  (byte_s1),
		.result     (mres)
	);

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_comb begin
		code      = mres.hit ? {4'b0001, mres.idx} : byte_s1;
		len       = mres.hit ? 4'(bscp_pkg::SHORT_LEN) : 4'(bscp_pkg::RAW_LEN);
		total     = 4'(pend_count_q) + len;
		acc       = (15'(pend_bits_q) << len) | 15'(code);
		full      = total >= 4'(bscp_pkg::RAW_LEN);
		rem       = full ? 3'(total - 4'(bscp_pkg::RAW_LEN)) : 3'(total);
		full_byte = 8'(acc >> rem);
		rem_bits  = 7'(acc & ((15'd1 << rem) - 15'd1));
		pad_w     = 15'(rem_bits) << (4'(bscp_pkg::RAW_LEN) - 4'(rem));
		pad_byte  = pad_w[7:0];
		flush     = last_s1 && (rem != 3'd0);
	end

	always_comb begin
		push       = fire && (full || flush);
		pair.byte0 = full ? full_byte : pad_byte;
		pair.byte1 = pad_byte;
		pair.two   = full && flush;
		pair.last  = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			pend_bits_q  <= '0;
			pend_count_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				pend_bits_q  <= last_s1 ? 7'd0 : rem_bits;
				pend_count_q <= last_s1 ? 3'd0 : rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

endmodule

@@ src/bscp_obuf.sv @@
// ---------------------------------------------------------------------------
// bscp_obuf
// Result buffer: small queue of byte pairs, sent one byte per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bscp_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bscp_pkg::pair_t pair,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            out_run_last,
	output logic            out_stream_last
);

	localparam int PtrW = $clog2(bscp_pkg::OBUF_DEPTH);
	localparam int CntW = $clog2(bscp_pkg::OBUF_DEPTH + 1);

	bscp_pkg::pair_t mem [bscp_pkg::OBUF_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            sub_q;

	bscp_pkg::pair_t head;
	logic            second;
	logic            take;
	logic            pop;

	assign head      = mem[rd_ptr_q];
	assign out_valid = count_q != '0;
	assign room      = count_q != CntW'(bscp_pkg::OBUF_DEPTH);
	assign second    = head.two && !sub_q;
	assign take      = out_valid && out_ready;
	assign pop       = take && !second;

	always_comb begin
		out_byte        = (head.two && sub_q) ? head.byte1 : head.byte0;
		out_run_last    = !second;
		out_stream_last = !second && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (take) begin
				sub_q <= second;
			end
			count_q <= count_q + CntW'(push) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= pair;
		end
	end

endmodule

@@ src/top_byte_short_code_packer.sv @@
// ---------------------------------------------------------------------------
// top_byte_short_code_packer
// Packs bytes into a bit stream, coding table bytes as 5-bit short codes.
// ---------------------------------------------------------------------------
//  Channel  Dir  Payload
//  s_axis   in   tdata = data_byte, tlast = end_of_input
//  m_axis   out  tdata = packed_byte, tuser = run_last, tlast = stream_last
//  cfg      in   cfg_index 0..2, cfg_data (always ready)
//
//  One input byte per cycle while the result queue has room. An input that
//  yields two bytes holds the output port for both, so the output port sets
//  the sustained rate at one byte per cycle while the receiver is ready.
//  Reset clears pending bits and the result queue; the table resets to
//  zero and the entry count to 15. Output stalls back up through the
//  two-entry result queue into the input register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_byte_short_code_packer #(
	parameter int TABLE_ENTRIES = bscp_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] packed_byte
	output logic        m_axis_tuser,   // [0] run_last
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [bscp_pkg::LOW_BITS-1:0]   table_low_q;
	logic [bscp_pkg::HIGH_BITS-1:0]  table_high_q;
	logic [bscp_pkg::COUNT_BITS-1:0] entry_count_q;

	logic            room;
	logic            push;
	bscp_pkg::pair_t pair;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_low_q   <= '0;
			table_high_q  <= '0;
			entry_count_q <= bscp_pkg::ENTRY_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bscp_pkg::CFG_TABLE_LOW:   table_low_q   <= cfg_data;
				bscp_pkg::CFG_TABLE_HIGH:  table_high_q  <= cfg_data[bscp_pkg::HIGH_BITS-1:0];
				bscp_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data[bscp_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	bscp_pack #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_bytes({table_high_q, table_low_q}),
		.entry_count(entry_count_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.room       (room),
		.push       (push),
		.pair       (pair)
	);

	bscp_obuf u_obuf (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.pair           (pair),
		.room           (room),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (m_axis_tdata),
		.out_run_last   (m_axis_tuser),
		.out_stream_last(m_axis_tlast)
	);

endmodule

@@ src/bscp_port_check.sv @@
// ---------------------------------------------------------------------------
// bscp_port_check
// Port-level checks of the packer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_byte_short_code_packer_macros.svh"

module bscp_port_check (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	`BSCP_ASSERT(a_stream_last_ends_run, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser, "stream_last without run_last")
	`BSCP_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tuser, m_axis_tvalid, "run cut short")
	`BSCP_ASSERT(a_idle_accepts, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
	`BSCP_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

endmodule

bind top_byte_short_code_packer bscp_port_check u_port_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

@@ sim/tb_top_byte_short_code_packer.sv @@
// ---------------------------------------------------------------------------
// tb_top_byte_short_code_packer
// Self-checking bench for the byte short code packer. A directed table walks
// reset values, field extremes, duplicate table bytes, an entry count of zero,
// an unused register index and the flush cases. Random phases follow, each
// with its own table. Every input transaction runs through a bit-accurate
// packer model, and each output transaction is checked against the oldest
// expected byte. Both stream sides idle at random, and the receiver holds off
// once for a long stretch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top_byte_short_code_packer;

	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	localparam logic [1:0] PREDICT      = 2'd3;
	localparam logic [7:0] SHORT_MARK   = 8'h10;
	localparam int NUM_ROWS      = 28;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 315;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int LIMIT_CYCLES  = 500000;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       run_last;
		logic       stream_last;
	} packed_out_t;

	typedef enum logic {ROW_DATA, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [63:0] reg_val;
		logic [7:0]  din;
		logic        din_last;
		logic [1:0]  nfix;
		packed_out_t fix0;
		packed_out_t fix1;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = bscp_pkg::CFG_TABLE_LOW;
	logic [63:0] cfg_data = '0;

	logic [1:0]  row_nfix = PREDICT;
	packed_out_t row_fix0 = '0;
	packed_out_t row_fix1 = '0;

	logic [63:0]                     tbl_lo = '0;
	logic [55:0]                     tbl_hi = '0;
	logic [bscp_pkg::COUNT_BITS-1:0] n_entries = bscp_pkg::ENTRY_COUNT_RST;
	logic [6:0]                      pend_bits = '0;
	int                              pend_cnt = 0;

	packed_out_t expected_bytes [$];
	int          errors = 0;
	int          cycles = 0;
	logic        no_idle = 1'b0;
	logic        hold_req = 1'b0;

	dir_row_t directed_rows [NUM_ROWS] = '{
		'{ROW_DATA, '0, '0, 8'h00, 1'b1, 2'd1, {8'h80, 2'b11}, '0},
		'{ROW_DATA, '0, '0, 8'hFF, 1'b1, 2'd1, {8'hFF, 2'b11}, '0},
		'{ROW_DATA, '0, '0, 8'h7F, 1'b0, 2'd1, {8'h7F, 2'b10}, '0},
		'{ROW_DATA, '0, '0, 8'h80, 1'b0, 2'd1, {8'h80, 2'b10}, '0},
		'{ROW_DATA, '0, '0, 8'h01, 1'b1, 2'd1, {8'h01, 2'b11}, '0},
		'{ROW_DATA, '0, '0, 8'h00, 1'b0, 2'd0, '0, '0},
		'{ROW_DATA, '0, '0, 8'h00, 1'b0, 2'd1, {8'h84, 2'b10}, '0},
		'{ROW_DATA, '0, '0, 8'hFF, 1'b1, 2'd2, {8'h3F, 2'b00}, {8'hC0, 2'b11}},
		'{ROW_CFG, bscp_pkg::CFG_TABLE_LOW, 64'h0706_0504_0302_0100, '0, 1'b0, '0, '0, '0},
		'{ROW_CFG, bscp_pkg::CFG_TABLE_HIGH, 64'hFF0E_0D0C_0B0A_0908, '0, 1'b0, '0, '0, '0},
		'{ROW_DATA, '0, '0, 8'h0E, 1'b0, PREDICT, '0, '0},
		'{ROW_DATA, '0, '0, 8'h0F, 1'b1, PREDICT, '0, '0},
		'{ROW_DATA, '0, '0, 8'h07, 1'b0, PREDICT, '0, '0},
		'{ROW_DATA, '0, '0, 8'h08, 1'b1, PREDICT, '0, '0},
		'{ROW_CFG, bscp_pkg::CFG_ENTRY_COUNT, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1'b0, '0, '0, '0},
		'{ROW_DATA, '0, '0, 8'h00, 1'b1, 2'd1, {8'h00, 2'b11}, '0},
		'{ROW_CFG, CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, '0, '0},
		'{ROW_CFG, bscp_pkg::CFG_TABLE_LOW, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, '0, '0},
		'{ROW_CFG, bscp_pkg::CFG_TABLE_HIGH, 64'h0, '0, 1'b0, '0, '0, '0},
		'{ROW_CFG, bscp_pkg::CFG_ENTRY_COUNT, 64'hF, '0, 1'b0, '0, '0, '0},
		'{ROW_DATA, '0, '0, 8'hFF, 1'b1, 2'd1, {8'h80, 2'b11}, '0},
		'{ROW_DATA, '0, '0, 8'h00, 1'b1, 2'd1, {8'hC0, 2'b11}, '0},
		'{ROW_CFG, bscp_pkg::CFG_ENTRY_COUNT, 64'h1, '0, 1'b0, '0, '0, '0},
		'{ROW_DATA, '0, '0, 8'h00, 1'b1, 2'd1, {8'h00, 2'b11}, '0},
		'{ROW_DATA, '0, '0, 8'hFF, 1'b0, 2'd0, '0, '0},
		'{ROW_DATA, '0, '0, 8'hFF, 1'b1, 2'd2, {8'h84, 2'b00}, {8'h00, 2'b11}},
		'{ROW_DATA, '0, '0, 8'h5A, 1'b0, PREDICT, '0, '0},
		'{ROW_DATA, '0, '0, 8'hA5, 1'b1, PREDICT, '0, '0}
	};

	top_byte_short_code_packer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int code_and_pack(input logic [7:0] b, input logic last,
			output packed_out_t r0, output packed_out_t r1);
		logic [119:0] tbl;
		logic [7:0]   code;
		logic [15:0]  acc;
		logic         hit;
		int           len;
		int           total;
		int           lim;
		int           n;
		packed_out_t  res [2];
		tbl = {tbl_hi, tbl_lo};
		code = b;
		len = bscp_pkg::RAW_LEN;
		hit = 1'b0;
		lim = (int'(n_entries) > bscp_pkg::TABLE_ENTRIES_MAX) ?
			bscp_pkg::TABLE_ENTRIES_MAX : int'(n_entries);
		for (int i = 0; i < lim; i++) begin
			if (!hit && tbl[8*i +: 8] == b) begin
				hit = 1'b1;
				code = SHORT_MARK | 8'(i);
				len = bscp_pkg::SHORT_LEN;
			end
		end
		total = pend_cnt + len;
		acc = (16'(pend_bits) << len) | 16'(code);
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (total >= 8) begin
			total -= 8;
			res[n].packed_byte = 8'(acc >> total);
			n++;
			acc &= (16'd1 << total) - 16'd1;
		end
		if (last && total > 0) begin
			res[n].packed_byte = 8'(acc << (8 - total));
			n++;
		end
		if (last) begin
			acc = '0;
			total = 0;
		end
		pend_bits = acc[6:0];
		pend_cnt = total;
		if (n > 0) begin
			res[n-1].run_last = 1'b1;
			res[n-1].stream_last = last;
		end
		r0 = res[0];
		r1 = res[1];
		return n;
	endfunction

	task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
		errors++;
		$display("%0t mismatch %s expected %02h actual %02h", $time, field, want, got);
	endtask

	always @(posedge clk) begin : monitor
		packed_out_t want;
		packed_out_t r0;
		packed_out_t r1;
		int          n;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					flag_field("unexpected packed_byte", 8'h00, m_axis_tdata);
				end else begin
					want = expected_bytes.pop_front();
					if (want.packed_byte !== m_axis_tdata)
						flag_field("packed_byte", want.packed_byte, m_axis_tdata);
					if (want.run_last !== m_axis_tuser)
						flag_field("run_last", 8'(want.run_last), 8'(m_axis_tuser));
					if (want.stream_last !== m_axis_tlast)
						flag_field("stream_last", 8'(want.stream_last), 8'(m_axis_tlast));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bscp_pkg::CFG_TABLE_LOW: begin
						tbl_lo = cfg_data;
					end
					bscp_pkg::CFG_TABLE_HIGH: begin
						tbl_hi = cfg_data[55:0];
					end
					bscp_pkg::CFG_ENTRY_COUNT: begin
						n_entries = cfg_data[bscp_pkg::COUNT_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n = code_and_pack(s_axis_tdata, s_axis_tlast, r0, r1);
				if (row_nfix != PREDICT) begin
					n = row_nfix;
					r0 = row_fix0;
					r1 = row_fix1;
				end
				if (n > 0)
					expected_bytes.push_back(r0);
				if (n > 1)
					expected_bytes.push_back(r1);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : receiver
		int   n;
		logic hold_taken;
		hold_taken = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last, input logic [1:0] nfix,
			input packed_out_t f0, input packed_out_t f1);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		row_nfix <= nfix;
		row_fix0 <= f0;
		row_fix1 <= f1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		dir_row_t                        row;
		logic [7:0]                      picks [bscp_pkg::TABLE_ENTRIES_MAX];
		logic [63:0]                     lo;
		logic [55:0]                     hi;
		logic [bscp_pkg::COUNT_BITS-1:0] cnt;
		logic [7:0]                      b;
		logic                            last;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < NUM_ROWS; r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.din, row.din_last, row.nfix, row.fix0, row.fix1);
			end
		end
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			no_idle = (ph == 3);
			for (int i = 0; i < bscp_pkg::TABLE_ENTRIES_MAX; i++) begin
				if (ph == 5 && i > 0)
					picks[i] = picks[0];
				else if (i > 0 && $urandom_range(0, 3) == 0)
					picks[i] = picks[i-1];
				else
					picks[i] = 8'($urandom_range(0, 255));
			end
			for (int i = 0; i < 8; i++)
				lo[8*i +: 8] = picks[i];
			for (int i = 8; i < bscp_pkg::TABLE_ENTRIES_MAX; i++)
				hi[8*(i-8) +: 8] = picks[i];
			case (ph)
				0: cnt = 4'd15;
				2: cnt = 4'd0;
				4: cnt = 4'd1;
				default: cnt = 4'($urandom_range(0, 15));
			endcase
			write_reg(bscp_pkg::CFG_TABLE_LOW, lo);
			write_reg(bscp_pkg::CFG_TABLE_HIGH, {8'($urandom), hi});
			write_reg(bscp_pkg::CFG_ENTRY_COUNT, {60'({$urandom, $urandom}), cnt});
			if (ph == 1)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 1) == 0)
					b = picks[$urandom_range(0, bscp_pkg::TABLE_ENTRIES_MAX - 1)];
				else
					b = 8'($urandom_range(0, 255));
				last = ($urandom_range(0, 11) == 0) ||
					(ph == NUM_PHASES - 1 && k == PHASE_ITEMS - 1);
				send_item(b, last, PREDICT, '0, '0);
			end
		end
		wait_idle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
